// ----- hw/rtl/days_between_dates_core_defines.svh -----
// Assertion macros for the RTL of the date difference block.
`ifndef DAYS_BETWEEN_DATES_CORE_DEFINES_SVH
`define DAYS_BETWEEN_DATES_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DBD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date difference check failed");

// The consequent must hold in the cycle after the antecedent.
`define DBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date difference check failed");

`else

`define DBD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DBD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/dbd_pkg.sv -----
package dbd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 23;
  localparam int unsigned LEN_W   = 5;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [8:0] DAYS_IN_YEAR = 9'd365;

  // Last residues of the 100-year and 400-year periods of the leap year rule.
  localparam logic [6:0] CENTURY_LAST = 7'd99;
  localparam logic [8:0] ERA_LAST     = 9'd399;

  // Control word from the sequencer to the shared adder.
  typedef struct packed {
    logic                      clear;
    logic                      add;
    logic signed [COUNT_W-1:0] operand;
  } acc_ctl_t;

  // Length of month m; zero for a month code outside the year.
  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [LEN_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/dbd_dates_if.sv -----
interface dbd_dates_if;
  import dbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   first_day;
  logic [MONTH_W-1:0] first_month;
  logic [YEAR_W-1:0]  first_year;
  logic [DAY_W-1:0]   second_day;
  logic [MONTH_W-1:0] second_month;
  logic [YEAR_W-1:0]  second_year;

  modport source(output valid, first_day, first_month, first_year,
                 second_day, second_month, second_year, input ready);
  modport sink(input valid, first_day, first_month, first_year,
               second_day, second_month, second_year, output ready);
endinterface

// ----- hw/rtl/dbd_result_if.sv -----
interface dbd_result_if;
  import dbd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] day_count;
  logic                      dates_valid;

  modport source(output valid, day_count, dates_valid, input ready);
  modport sink(input valid, day_count, dates_valid, output ready);
endinterface

// ----- hw/rtl/days_between_dates_core.sv -----
// Day count between two Gregorian dates.
// A word on the dates channel carries two dates (day, month, year). For each
// accepted word exactly one word leaves on the result channel: the signed
// number of days from the first date to the second, and a flag that is high
// when both dates are real calendar dates with years from 1 to MAX_YEAR.
// An invalid date gives a count of zero with the flag low; a second year
// earlier than the first gives zero with the flag high.
// One adder sums the whole count. A year counter walks from year 1 up to the
// later of the two years, one year per cycle, tracking the leap rule with
// residue counters and summing the whole years between the dates; then a
// month counter walks up to the later month, one month per cycle, adding
// the day-of-year difference. A year or month out of range skips the walk.
// The dates channel is ready only while no item is in progress.
// The result sits in an output register until taken; a stalled receiver
// holds the finished item in the last step, so no result is ever lost.
// A synchronous reset returns to idle and drops any result not yet taken.
`include "days_between_dates_core_defines.svh"

module days_between_dates_core #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input logic          clk,
  input logic          rst,
  dbd_dates_if.sink    dates,
  dbd_result_if.source result
);
  import dbd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MONTH,
    S_FIN
  } state_t;

  state_t state;

  // Captured item.
  logic [DAY_W-1:0]   d1, d2;
  logic [MONTH_W-1:0] m1, m2, mmax, mi;
  logic [YEAR_W-1:0]  y1, y2, ymax;
  logic               leap1, leap2, range_ok;

  // Output register.
  logic                      out_valid;
  logic signed [COUNT_W-1:0] out_count;
  logic                      out_dates_valid;

  logic                      accept;
  logic                      in_range;
  logic                      walk_start, walk_step;
  logic [YEAR_W-1:0]         year;
  logic                      leap;
  acc_ctl_t                  acc_ctl;
  logic signed [COUNT_W-1:0] sum;

  logic [LEN_W-1:0]  len1, len2;
  logic signed [6:0] month_delta, day_delta;
  logic              days_ok, out_free, result_load;

  assign dates.ready = (state == S_IDLE);
  assign accept      = dates.valid && dates.ready;

  // Years and months are checked at once; days need the leap bits.
  assign in_range = (dates.first_year != '0) && (32'(dates.first_year) <= MAX_YEAR)
                 && (dates.second_year != '0) && (32'(dates.second_year) <= MAX_YEAR)
                 && (dates.first_month >= MONTH_JAN) && (dates.first_month <= MONTH_DEC)
                 && (dates.second_month >= MONTH_JAN) && (dates.second_month <= MONTH_DEC);

  assign walk_start = accept;
  assign walk_step  = (state == S_SCAN) && (year != ymax);

  dbd_year_walk u_walk (
    .clk  (clk),
    .start(walk_start),
    .step (walk_step),
    .year (year),
    .leap (leap)
  );

  // Month step: days of month mi that lie before the second date, less
  // those that lie before the first.
  assign len2 = (mi < m2) ? month_len(mi, leap2) : '0;
  assign len1 = (mi < m1) ? month_len(mi, leap1) : '0;
  assign month_delta = $signed({2'b00, len2}) - $signed({2'b00, len1});
  assign day_delta   = $signed({2'b00, d2}) - $signed({2'b00, d1});

  assign days_ok = range_ok
                && (d1 != '0) && (d1 <= month_len(m1, leap1))
                && (d2 != '0) && (d2 <= month_len(m2, leap2));

  assign out_free    = !out_valid || result.ready;
  assign result_load = (state == S_FIN) && out_free;

  always_comb begin
    acc_ctl.clear   = accept;
    acc_ctl.add     = 1'b0;
    acc_ctl.operand = '0;
    case (state)
      S_SCAN: begin
        // Whole years from the first year up to, not including, the second.
        acc_ctl.add     = (year >= y1) && (year < y2);
        acc_ctl.operand = $signed(COUNT_W'(DAYS_IN_YEAR + 9'(leap)));
      end
      S_MONTH: begin
        acc_ctl.add     = (mi < mmax);
        acc_ctl.operand = {{(COUNT_W-7){month_delta[6]}}, month_delta};
      end
      S_FIN: begin
        acc_ctl.operand = {{(COUNT_W-7){day_delta[6]}}, day_delta};
      end
      default: begin
        acc_ctl.add = 1'b0;
      end
    endcase
  end

  dbd_acc u_acc (
    .clk(clk),
    .ctl(acc_ctl),
    .sum(sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result loads as the old one leaves; otherwise a taken word clears.
      out_valid <= result_load || (out_valid && !result.ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            d1       <= dates.first_day;
            m1       <= dates.first_month;
            y1       <= dates.first_year;
            d2       <= dates.second_day;
            m2       <= dates.second_month;
            y2       <= dates.second_year;
            ymax     <= (dates.second_year > dates.first_year) ?
                        dates.second_year : dates.first_year;
            mmax     <= (dates.second_month > dates.first_month) ?
                        dates.second_month : dates.first_month;
            range_ok <= in_range;
            state    <= in_range ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          if (year == y1) begin
            leap1 <= leap;
          end
          if (year == y2) begin
            leap2 <= leap;
          end
          if (year == ymax) begin
            mi    <= MONTH_JAN;
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (mi < mmax) begin
            mi <= mi + MONTH_W'(1);
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_dates_valid <= days_ok;
            out_count       <= (days_ok && (y2 >= y1)) ? sum : '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.day_count   = out_count;
  assign result.dates_valid = out_dates_valid;

  // An invalid pair always reports a zero count.
  `DBD_ASSERT_IMPLIES(a_invalid_zero, clk, rst, out_valid && !out_dates_valid, out_count == '0)
  // The year walk never passes the later of the two years.
  `DBD_ASSERT_IMPLIES(a_year_bound, clk, rst, state == S_SCAN, year <= ymax)
  // The month walk stays inside the calendar year.
  `DBD_ASSERT_IMPLIES(a_month_bound, clk, rst, state == S_MONTH, (mi >= MONTH_JAN) && (mi <= MONTH_DEC))
  // An accepted word always starts work.
  `DBD_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state == S_SCAN || state == S_FIN)

endmodule

// ----- hw/rtl/dbd_year_walk.sv -----
module dbd_year_walk (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  output logic [dbd_pkg::YEAR_W-1:0] year,
  output logic                       leap
);
  import dbd_pkg::*;

  // Year and its residues modulo 4, 100 and 400, advanced together.
  logic [1:0] mod4;
  logic [6:0] mod100;
  logic [8:0] mod400;

  always_ff @(posedge clk) begin
    if (start) begin
      year   <= YEAR_W'(1);
      mod4   <= 2'd1;
      mod100 <= 7'd1;
      mod400 <= 9'd1;
    end else if (step) begin
      year   <= year + YEAR_W'(1);
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == CENTURY_LAST) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == ERA_LAST) ? 9'd0 : mod400 + 9'd1;
    end
  end

  assign leap = (mod4 == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
endmodule

// ----- hw/rtl/dbd_acc.sv -----
module dbd_acc (
  input  logic                               clk,
  input  dbd_pkg::acc_ctl_t                  ctl,
  output logic signed [dbd_pkg::COUNT_W-1:0] sum
);
  import dbd_pkg::*;

  logic signed [COUNT_W-1:0] acc;

  // The adder that sums the count; the count wraps at its width.
  assign sum = acc + ctl.operand;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= sum;
    end
  end
endmodule
